// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the calibration top, the RTL file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/mmcal_pkg.sv -----
// Types and constants for the magnetometer min/max calibration block.
package mmcal_pkg;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned CalWidth = 24;
  localparam int unsigned NumAxes  = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_e;

endpackage

// ----- hw/rtl/magnetometer_minmax_calibration_top.sv -----
// Magnetometer min/max calibration with a bit-serial multiplier and divider.
//
// Input channel (s_axis_*): one transfer carries one X/Y/Z sample. On accept the
// running minimum and maximum of each axis are widened to include the sample.
// Output channel (m_axis_*): one transfer per input, carrying the three
// calibrated axes (2*raw - (max+min)) * (sum of spans) / (6*span), with
// FRAC_BITS fraction bits, truncated toward zero and clipped to 24 bits.
// tuser bit 0 is set when all spans are nonzero; otherwise the data is zero.
// tuser bit 1 is set when any axis was clipped.
//
// The axes share one shift-add multiplier with a SAMPLE_WIDTH+2-bit multiplier
// and one restoring divider that takes one quotient bit per cycle into a
// quotient of max(2*SAMPLE_WIDTH+2+FRAC_BITS, 25) bits; each axis also passes
// through a setup and a store state. A sample with a zero span skips the
// multiplier and divider and goes from setup straight to the output state.
// One item is in work at a time; s_axis_tready is high only when idle. The
// output register holds a finished result while the receiver stalls, and the
// next sample may be accepted in the meantime; its result waits until then.
// Reset clears the trackers to the widest empty range and empties the output.
module magnetometer_minmax_calibration_top #(
  parameter int unsigned FRAC_BITS    = 4,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_x, raw_y, raw_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // cal_x, cal_y, cal_z
  output logic [1:0]  m_axis_tuser    // valid_res, saturated
);

`include "assert_macros.svh"

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned EW = (SW > mmcal_pkg::InWidth) ? SW : mmcal_pkg::InWidth;
  localparam int unsigned TW = SW + 2;
  localparam int unsigned PW = SW + TW;
  localparam int unsigned NW = PW + FRAC_BITS;
  localparam int unsigned QW = (NW > mmcal_pkg::CalWidth + 1) ? NW
                                                              : mmcal_pkg::CalWidth + 1;
  localparam int unsigned DW = SW + 3;
  localparam int unsigned CW = $clog2(QW);
  localparam int unsigned OW = mmcal_pkg::CalWidth;

  localparam logic signed [SW-1:0] MinReset = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MaxReset = {1'b1, {(SW-1){1'b0}}};
  localparam logic [OW-1:0] OutMax = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] OutMin = {1'b1, {(OW-1){1'b0}}};

  mmcal_pkg::state_e state_q, state_d;

  logic signed [SW-1:0] raw_q [mmcal_pkg::NumAxes];
  logic signed [SW-1:0] min_q [mmcal_pkg::NumAxes];
  logic signed [SW-1:0] max_q [mmcal_pkg::NumAxes];
  logic [OW-1:0]        res_q [mmcal_pkg::NumAxes];
  logic                 valid_q, sat_q, neg_q;
  logic [1:0]           axis_q;
  logic [CW-1:0]        cnt_q;
  logic [SW-1:0]        mcand_q;
  logic [TW-1:0]        mplier_q;
  logic [PW-1:0]        acc_q, acc_d;
  logic [QW-1:0]        num_q, num_d;
  logic [DW-1:0]        rem_q, rem_d, den_q;
  logic                 m_tvalid_q;
  logic [71:0]          m_tdata_q;
  logic [1:0]           m_tuser_q;

  logic s_hs, out_free;
  logic do_setup, do_mul, do_div, do_store, do_out;
  logic minmax_ok, out_invalid, zero_out_ok;

  // Sample unpacking and sign extension from SAMPLE_WIDTH bits.
  logic [EW-1:0]        s_ext [mmcal_pkg::NumAxes];
  logic signed [SW-1:0] s_raw [mmcal_pkg::NumAxes];
  always_comb begin
    for (int i = 0; i < mmcal_pkg::NumAxes; i++) begin
      s_ext[i] = EW'(s_axis_tdata[i*mmcal_pkg::InWidth +: mmcal_pkg::InWidth]);
      s_raw[i] = $signed(s_ext[i][SW-1:0]);
    end
  end

  // Spans and their sum.
  logic [SW:0]   span_full [mmcal_pkg::NumAxes];
  logic [SW-1:0] span [mmcal_pkg::NumAxes];
  logic          any_zero;
  logic [TW-1:0] total;
  always_comb begin
    any_zero = 1'b0;
    for (int i = 0; i < mmcal_pkg::NumAxes; i++) begin
      span_full[i] = (SW+1)'($signed({max_q[i][SW-1], max_q[i]}) -
                             $signed({min_q[i][SW-1], min_q[i]}));
      span[i]      = span_full[i][SW-1:0];
      if (span[i] == '0) begin
        any_zero = 1'b1;
      end
    end
    total = TW'(span[0]) + TW'(span[1]) + TW'(span[2]);
  end

  // Per-axis operands for the current axis.
  logic signed [SW-1:0] sel_raw, sel_lo, sel_hi;
  logic [SW-1:0]        sel_span;
  logic signed [SW+1:0] diff, diff_abs;
  logic [DW-1:0]        den;
  always_comb begin
    sel_raw  = raw_q[axis_q];
    sel_lo   = min_q[axis_q];
    sel_hi   = max_q[axis_q];
    sel_span = span[axis_q];
    diff     = ($signed({{2{sel_raw[SW-1]}}, sel_raw}) <<< 1) -
               ($signed({{2{sel_hi[SW-1]}}, sel_hi}) + $signed({{2{sel_lo[SW-1]}}, sel_lo}));
    diff_abs = diff[SW+1] ? -diff : diff;
    den      = DW'({sel_span, 2'b00}) + DW'({sel_span, 1'b0});
  end

  // One multiplier bit and one quotient bit per step.
  logic [DW:0] trial, trial_sub;
  logic        ge;
  always_comb begin
    acc_d     = {acc_q[PW-2:0], 1'b0} + (mplier_q[TW-1] ? PW'(mcand_q) : '0);
    trial     = {rem_q, num_q[QW-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = (trial >= {1'b0, den_q});
    rem_d     = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
    num_d     = {num_q[QW-2:0], ge};
  end

  // Clipping of the finished quotient.
  logic          big, sat_axis;
  logic [OW-1:0] q_lo, val;
  always_comb begin
    big  = |num_q[QW-1:OW];
    q_lo = num_q[OW-1:0];
    if (neg_q) begin
      sat_axis = big | (q_lo[OW-1] & (|q_lo[OW-2:0]));
      val      = sat_axis ? OutMin : (~q_lo + OW'(1));
    end else begin
      sat_axis = big | q_lo[OW-1];
      val      = sat_axis ? OutMax : q_lo;
    end
  end

  assign s_hs     = s_axis_tvalid & s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmcal_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = mmcal_pkg::ST_SETUP;
      end
      mmcal_pkg::ST_SETUP: begin
        state_d = any_zero ? mmcal_pkg::ST_OUT : mmcal_pkg::ST_MUL;
      end
      mmcal_pkg::ST_MUL: begin
        if (cnt_q == '0) state_d = mmcal_pkg::ST_DIV;
      end
      mmcal_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = mmcal_pkg::ST_STORE;
      end
      mmcal_pkg::ST_STORE: begin
        state_d = (axis_q == 2'd2) ? mmcal_pkg::ST_OUT : mmcal_pkg::ST_SETUP;
      end
      mmcal_pkg::ST_OUT: begin
        if (out_free) state_d = mmcal_pkg::ST_IDLE;
      end
      default: state_d = mmcal_pkg::ST_IDLE;
    endcase
  end

  // Control decode.
  always_comb begin
    s_axis_tready = 1'b0;
    do_setup      = 1'b0;
    do_mul        = 1'b0;
    do_div        = 1'b0;
    do_store      = 1'b0;
    do_out        = 1'b0;
    unique case (state_q)
      mmcal_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      mmcal_pkg::ST_SETUP: do_setup = 1'b1;
      mmcal_pkg::ST_MUL:   do_mul = 1'b1;
      mmcal_pkg::ST_DIV:   do_div = 1'b1;
      mmcal_pkg::ST_STORE: do_store = 1'b1;
      mmcal_pkg::ST_OUT:   do_out = out_free;
      default: ;
    endcase
  end

  // Control state and trackers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mmcal_pkg::ST_IDLE;
      axis_q     <= '0;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
      for (int i = 0; i < mmcal_pkg::NumAxes; i++) begin
        min_q[i] <= MinReset;
        max_q[i] <= MaxReset;
      end
    end else begin
      state_q <= state_d;
      if (s_hs) begin
        axis_q <= '0;
        for (int i = 0; i < mmcal_pkg::NumAxes; i++) begin
          if (s_raw[i] < min_q[i]) min_q[i] <= s_raw[i];
          if (s_raw[i] > max_q[i]) max_q[i] <= s_raw[i];
        end
      end
      if (do_setup) begin
        cnt_q <= CW'(TW - 1);
      end else if (do_mul && cnt_q == '0) begin
        cnt_q <= CW'(QW - 1);
      end else if (do_mul || do_div) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (do_store) axis_q <= axis_q + 2'd1;
      if (do_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      raw_q   <= s_raw;
      valid_q <= 1'b1;
      sat_q   <= 1'b0;
    end
    if (do_setup) begin
      if (any_zero) begin
        valid_q <= 1'b0;
        for (int i = 0; i < mmcal_pkg::NumAxes; i++) begin
          res_q[i] <= '0;
        end
      end
      neg_q    <= diff[SW+1];
      mcand_q  <= diff_abs[SW-1:0];
      mplier_q <= total;
      acc_q    <= '0;
      rem_q    <= '0;
      den_q    <= den;
    end
    if (do_mul) begin
      acc_q    <= acc_d;
      mplier_q <= {mplier_q[TW-2:0], 1'b0};
      if (cnt_q == '0) num_q <= QW'(acc_d) << FRAC_BITS;
    end
    if (do_div) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    if (do_store) begin
      res_q[axis_q] <= val;
      sat_q         <= sat_q | sat_axis;
    end
    if (do_out) begin
      m_tdata_q <= {res_q[2], res_q[1], res_q[0]};
      m_tuser_q <= {sat_q, valid_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  assign minmax_ok   = (min_q[0] <= max_q[0]) && (min_q[1] <= max_q[1]) &&
                       (min_q[2] <= max_q[2]);
  assign out_invalid = m_axis_tvalid && !m_axis_tuser[0];
  assign zero_out_ok = (m_axis_tdata == '0) && !m_axis_tuser[1];

  `ASSERT_RST(a_minmax_order, s_hs |=> minmax_ok, "tracker minimum above maximum")
  `ASSERT_RST(a_invalid_zero, out_invalid |-> zero_out_ok, "zero-span result carries data")
  `ASSERT_RST(a_div_count, do_div |-> (cnt_q < CW'(QW)), "divider step count out of range")
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

endmodule

// ----- tb/mmcal_checker.sv -----
// Tracks the min/max calibration state and checks every output transfer against it.
`timescale 1ns / 1ps

module mmcal_checker #(
  parameter int unsigned FracBits    = 4,
  parameter int unsigned SampleWidth = 16
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           s_axis_tvalid,
  input  logic                                           s_axis_tready,
  input  logic [mmcal_pkg::NumAxes*mmcal_pkg::InWidth-1:0]  s_axis_tdata,  // raw_x, raw_y, raw_z
  input  logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  input  logic [mmcal_pkg::NumAxes*mmcal_pkg::CalWidth-1:0] m_axis_tdata,  // cal_x, cal_y, cal_z
  input  logic [1:0]                                     m_axis_tuser,  // valid_res, saturated
  output int                                             mismatch_count_o,
  output int                                             pending_o
);

  localparam int unsigned NumAxes  = mmcal_pkg::NumAxes;
  localparam int unsigned InWidth  = mmcal_pkg::InWidth;
  localparam int unsigned CalWidth = mmcal_pkg::CalWidth;

  localparam longint CalMax = (longint'(1) << (CalWidth - 1)) - 1;
  localparam longint CalMin = -(longint'(1) << (CalWidth - 1));

  // Packed so that the flags line up with tuser: saturated above valid_res.
  typedef struct packed {
    logic [NumAxes-1:0][CalWidth-1:0] cal;
    logic                             saturated;
    logic                             valid_res;
  } cal_result_t;

  int          axis_lo[NumAxes];
  int          axis_hi[NumAxes];
  cal_result_t expected_cal_q[$];
  int          mismatch_count = 0;
  string       axis_name[NumAxes] = '{"cal_x", "cal_y", "cal_z"};

  assign mismatch_count_o = mismatch_count;

  function automatic int sample_value(input logic [InWidth-1:0] field);
    int v;
    v = int'(field) & ((1 << SampleWidth) - 1);
    if (v >= (1 << (SampleWidth - 1))) v -= (1 << SampleWidth);
    return v;
  endfunction

  // Returns the clipped 24-bit value with the clip flag above it.
  function automatic logic [CalWidth:0] calibrate_axis(input int raw, input int lo,
                                                       input int hi, input longint total);
    longint          diff;
    longint          span;
    longint unsigned mag;
    longint unsigned quo;
    longint          val;
    logic            neg;
    logic            sat;
    diff = 2 * longint'(raw) - (longint'(hi) + longint'(lo));
    span = longint'(hi) - longint'(lo);
    neg  = diff < 0;
    mag  = neg ? longint'(-diff) : diff;
    // Division on magnitudes truncates toward zero once the sign is put back.
    quo  = ((mag * longint'(total)) << FracBits) / longint'(span * 6);
    sat  = 1'b0;
    if (neg) begin
      if (quo > longint'(-CalMin)) begin
        sat = 1'b1;
        val = CalMin;
      end else begin
        val = -longint'(quo);
      end
    end else if (quo > longint'(CalMax)) begin
      sat = 1'b1;
      val = CalMax;
    end else begin
      val = longint'(quo);
    end
    return {sat, val[CalWidth-1:0]};
  endfunction

  function automatic cal_result_t predict_calibration(input logic [NumAxes*InWidth-1:0] data);
    int           raw[NumAxes];
    longint       total;
    logic         all_spans;
    logic [CalWidth:0] axis_res;
    cal_result_t  res;
    res       = '0;
    total     = 0;
    all_spans = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      raw[i] = sample_value(data[i*InWidth +: InWidth]);
      if (raw[i] < axis_lo[i]) axis_lo[i] = raw[i];
      if (raw[i] > axis_hi[i]) axis_hi[i] = raw[i];
    end
    for (int i = 0; i < NumAxes; i++) begin
      if (axis_hi[i] - axis_lo[i] <= 0) all_spans = 1'b0;
      else total += axis_hi[i] - axis_lo[i];
    end
    // While any axis has collapsed to a point the whole result stays zero.
    if (all_spans) begin
      res.valid_res = 1'b1;
      for (int i = 0; i < NumAxes; i++) begin
        axis_res      = calibrate_axis(raw[i], axis_lo[i], axis_hi[i], total);
        res.cal[i]    = axis_res[CalWidth-1:0];
        res.saturated = res.saturated | axis_res[CalWidth];
      end
    end
    return res;
  endfunction

  task automatic flag_field(input string field, input longint exp_v, input longint act_v);
    if (mismatch_count < 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cal_result_t exp_res;
    cal_result_t act_res;
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        axis_lo[i] = (1 << (SampleWidth - 1)) - 1;
        axis_hi[i] = -(1 << (SampleWidth - 1));
      end
      expected_cal_q.delete();
      pending_o <= 0;
    end else begin
      // Results leave before the new sample is logged, so a result can never
      // be matched against the sample accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        act_res = {m_axis_tdata, m_axis_tuser[1], m_axis_tuser[0]};
        if (expected_cal_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result transfer with no sample outstanding, data %0h user %0h",
                     $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          exp_res = expected_cal_q.pop_front();
          for (int i = 0; i < NumAxes; i++)
            if (act_res.cal[i] !== exp_res.cal[i])
              flag_field(axis_name[i], exp_res.cal[i], act_res.cal[i]);
          if (act_res.valid_res !== exp_res.valid_res)
            flag_field("valid_res", exp_res.valid_res, act_res.valid_res);
          if (act_res.saturated !== exp_res.saturated)
            flag_field("saturated", exp_res.saturated, act_res.saturated);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_cal_q.push_back(predict_calibration(s_axis_tdata));
      pending_o <= expected_cal_q.size();
    end
  end

endmodule

// ----- tb/tb_magnetometer_minmax_calibration_top.sv -----
// Stimulus and verdict for the magnetometer min/max calibration block.
`timescale 1ns / 1ps

module tb_magnetometer_minmax_calibration_top;

  localparam int unsigned FracBits    = 4;
  localparam int unsigned SampleWidth = 16;
  localparam int          RandomItems = 640;
  localparam int          TotalItems  = 655;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // raw_x, raw_y, raw_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // cal_x, cal_y, cal_z
  logic [1:0]  m_axis_tuser;        // valid_res, saturated

  int mismatch_count;
  int pending_count;
  int tx_idle_pct = 18;
  int rx_idle_pct = 71;
  int sent_count  = 0;

  always #1 clk_i = ~clk_i;

  magnetometer_minmax_calibration_top #(
    .FRAC_BITS   (FracBits),
    .SAMPLE_WIDTH(SampleWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  mmcal_checker #(
    .FracBits   (FracBits),
    .SampleWidth(SampleWidth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Each call ends at the edge where the sample transfer completes; tvalid is
  // only dropped during a gap so it never toggles twice in one step.
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    if (sent_count == TotalItems / 3) begin
      tx_idle_pct = 71;
      rx_idle_pct = 18;
    end else if (sent_count == 2 * TotalItems / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Random sample within +/- reach of zero, clipped to the 16-bit range.
  function automatic logic [15:0] near_value(input int reach);
    int v;
    v = int'($urandom_range(2 * reach)) - reach;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first samples leave at least one axis with no span.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1, 16'sd0);
    // All spans are one for these two samples; results of both signs come out exact.
    send_sample(16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd1, 16'sd1, -16'sd1);
    // Y opens to full scale while X and Z stay narrow: the largest gain on X and Z.
    send_sample(16'sd1, -16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd32767, -16'sd1);
    send_sample(16'sd1, -16'sd1, 16'sd0);
    send_sample(16'sd0, 16'h5555, -16'sd1);
    send_sample(16'sd1, 16'hAAAA, 16'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd1);

    // X and Z widen at different rates so the gain ratios keep moving.
    for (int k = 0; k < RandomItems; k++) begin
      if (k == RandomItems / 2) hold_until_drained();
      send_sample(near_value(1 << ((k * 15) / RandomItems)), 16'($urandom),
                  near_value(1 << ((k * 12) / RandomItems)));
    end

    send_sample(-16'sd32768, 16'sd0, -16'sd32768);
    send_sample(16'sd32767, -16'sd1, 16'sd32767);
    send_sample(16'sd0, 16'sd0, 16'sd0);

    hold_until_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
